// ===== rtl/ascii_three_to_four_encoder_top_defines.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef ASCII_THREE_TO_FOUR_ENCODER_TOP_DEFINES_SVH
`define ASCII_THREE_TO_FOUR_ENCODER_TOP_DEFINES_SVH

// Clocked property checked outside reset.
`define ENC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property checked during reset as well.
`define ENC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/a3to4_pkg.sv =====
// Types, constants and the group encoding function of the three-to-four encoder.
`default_nettype none
package a3to4_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int CHAR_WIDTH  = 7;
   localparam int LIMIT_WIDTH = 16;
   localparam int OUT_COUNT_WIDTH = 16;
   localparam int GROUP_CHARS = 4;

   localparam logic [CHAR_WIDTH-1:0]  CHAR_OFFSET = 7'd32;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

   // Register word indexes on the configuration port.
   localparam logic REG_OUTPUT_LIMIT = 1'b0;

   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [GROUP_CHARS-1:0][CHAR_WIDTH-1:0] char_quad_type;

   // Splits three bytes into four six-bit slices, most significant first,
   // and lifts each into the printable range. Slot 0 is the first character.
   function automatic char_quad_type encode_group(input byte_type b0, input byte_type b1,
                                                  input byte_type b2);
      char_quad_type q;
      q[0] = {1'b0, b0[7:2]} + CHAR_OFFSET;
      q[1] = {1'b0, b0[1:0], b1[7:4]} + CHAR_OFFSET;
      q[2] = {1'b0, b1[3:0], b2[7:6]} + CHAR_OFFSET;
      q[3] = {1'b0, b2[5:0]} + CHAR_OFFSET;
      return q;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ascii_three_to_four_encoder_top.sv =====
// A byte that closes a group shows its first character on rsp in the cycle after acceptance.
// The drain register gives one character per cycle while rsp_tready is high; a closing byte waits
// until the previous group's last character is taken.
// Bytes that do not close a group, and bytes absorbed after the cap, are taken every cycle.
// Reset (synchronous, active high) empties the group and the drain register, zeroes the
// message count and sets output_limit to 65535; no clearing pass is needed.
`default_nettype none
`include "ascii_three_to_four_encoder_top_defines.svh"
module ascii_three_to_four_encoder_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // final_byte
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [6:0] out_char, [22:7] chars_so_far, [23] zero
   output logic             rsp_tlast,   // end_of_output
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import a3to4_pkg::*;

   localparam int CW = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
   localparam logic [LIMIT_WIDTH-1:0] CAP_MAX = (COUNT_WIDTH >= LIMIT_WIDTH) ?
      LIMIT_RESET : LIMIT_WIDTH'((33'd1 << COUNT_WIDTH) - 33'd1);

   // Configuration register.
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;

   // Message state.
   logic [15:0]            held_ff, held_in;
   logic [1:0]             fill_ff, fill_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   limited_ff, limited_in;

   // Drain register holding the characters of one group.
   char_quad_type              chars_ff, chars_in;
   logic [OUT_COUNT_WIDTH-1:0] out_cnt_ff, out_cnt_in;
   logic [1:0]                 rem_ff, rem_in;
   logic                       end_ff, end_in;
   logic                       busy_ff, busy_in;

   logic req_fire, rsp_fire, completes, drain_free, csr_write;
   byte_type b0, b1, b2;
   logic [LIMIT_WIDTH-1:0] lim1, cap;
   logic [CW-1:0] diff;
   logic [2:0] n_chars;
   logic hit, over;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_OUTPUT_LIMIT) ?
                       {{(32-LIMIT_WIDTH){1'b0}}, limit_ff} : 32'd0;

   assign completes  = !limited_ff && ((fill_ff == 2'd2) || req_tlast);
   assign drain_free = !busy_ff || (rsp_tready && (rem_ff == 2'd0));
   assign req_tready = !completes || drain_free;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {1'b0, out_cnt_ff, chars_ff[0]};
   assign rsp_tlast  = end_ff && (rem_ff == 2'd0);

   // Bytes of the group being closed; missing bytes are padded with zero.
   always_comb begin
      b0 = held_ff[15:8];
      b1 = held_ff[7:0];
      b2 = req_tdata;
      case (fill_ff)
         2'd0: begin
            b0 = req_tdata;
            b1 = '0;
            b2 = '0;
         end
         2'd1: begin
            b1 = req_tdata;
            b2 = '0;
         end
         default: ;
      endcase
   end

   // The cap is fixed for the whole group, so the number of characters that
   // fit is known at acceptance: at most four, at most what is left to the cap.
   // A limit lowered below the running count still lets one character out.
   always_comb begin
      lim1 = (limit_ff == '0) ? LIMIT_WIDTH'(1) : limit_ff;
      cap  = (lim1 > CAP_MAX) ? CAP_MAX : lim1;
      diff = CW'(cap) - CW'(count_ff);
      over = (CW'(count_ff) >= CW'(cap));
      hit  = over || (diff <= CW'(GROUP_CHARS));
      n_chars = over ? 3'd1 : (hit ? diff[2:0] : 3'd4);
   end

   always_comb begin
      limit_in   = csr_write && (csr_paddr[2] == REG_OUTPUT_LIMIT) ?
                   csr_pwdata[LIMIT_WIDTH-1:0] : limit_ff;
      held_in    = held_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      limited_in = limited_ff;
      chars_in   = chars_ff;
      out_cnt_in = out_cnt_ff;
      rem_in     = rem_ff;
      end_in     = end_ff;
      busy_in    = busy_ff;

      if (rsp_fire) begin
         chars_in   = chars_ff >> CHAR_WIDTH;
         out_cnt_in = out_cnt_ff + OUT_COUNT_WIDTH'(1);
         rem_in     = rem_ff - 2'd1;
         busy_in    = (rem_ff != 2'd0);
      end

      if (req_fire) begin
         if (completes) begin
            chars_in   = encode_group(b0, b1, b2);
            out_cnt_in = OUT_COUNT_WIDTH'(CW'(count_ff) + CW'(1));
            rem_in     = 2'(n_chars - 3'd1);
            end_in     = hit || req_tlast;
            busy_in    = 1'b1;
            held_in    = '0;
            fill_in    = 2'd0;
            count_in   = count_ff + COUNT_WIDTH'(n_chars);
            limited_in = hit;
         end else if (!limited_ff) begin
            if (fill_ff == 2'd0) begin
               held_in = {req_tdata, 8'd0};
            end else begin
               held_in = {held_ff[15:8], req_tdata};
            end
            fill_in = fill_ff + 2'd1;
         end
         // The end of a message returns all message state to reset.
         if (req_tlast) begin
            held_in    = '0;
            fill_in    = 2'd0;
            count_in   = '0;
            limited_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         held_ff    <= '0;
         fill_ff    <= 2'd0;
         count_ff   <= '0;
         limited_ff <= 1'b0;
         rem_ff     <= 2'd0;
         end_ff     <= 1'b0;
         busy_ff    <= 1'b0;
      end else begin
         limit_ff   <= limit_in;
         held_ff    <= held_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         limited_ff <= limited_in;
         rem_ff     <= rem_in;
         end_ff     <= end_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff   <= chars_in;
      out_cnt_ff <= out_cnt_in;
   end

   `ENC_ASSERT(a_group_shows, (req_fire && completes) |=> rsp_tvalid,
      "closed group produced no beat")
   `ENC_ASSERT(a_drain_ends,
      (rsp_fire && (rem_ff == 2'd0) && !(req_fire && completes)) |=> !busy_ff,
      "drain register still busy after its last beat")
   `ENC_ASSERT(a_count_nonzero, rsp_tvalid |-> (out_cnt_ff != '0),
      "beat carries a zero character count")
   `ENC_ASSERT(a_char_range,
      busy_ff |-> ((chars_ff[0] >= 7'd32) && (chars_ff[0] <= 7'd95)),
      "character outside the printable range")

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the three-to-four printable encoder, with random stream stalls.
module tb_top;
   import a3to4_pkg::*;

   localparam logic [2:0] CSR_ADDR_LIMIT  = 3'(4 * REG_OUTPUT_LIMIT);
   // Word 1 holds no register, so a write there must leave the limit alone.
   localparam logic [2:0] CSR_ADDR_UNUSED = 3'd4;
   localparam int unsigned SENT_TARGET = 345;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0]      code;
      logic                       closing;
      logic [OUT_COUNT_WIDTH-1:0] count;
   } enc_char_type;

   typedef struct {
      byte_type    data;
      logic        last;
      int unsigned gap;
      logic        pause;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] data_byte
   logic        req_tlast = 1'b0;  // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [6:0] out_char, [22:7] chars_so_far, [23] zero
   logic        rsp_tlast;         // end_of_output
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ascii_three_to_four_encoder_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Encoder state as the design should hold it.
   logic [LIMIT_WIDTH-1:0]     limit_reg = LIMIT_RESET;
   logic [15:0]                held_pair = '0;
   logic [1:0]                 group_fill = '0;
   logic [OUT_COUNT_WIDTH-1:0] char_count = '0;
   logic                       cap_hit = 1'b0;

   enc_char_type   pending_chars[$];
   byte_item_type  byte_queue[$];
   byte_item_type  beat;
   int unsigned gap_count = 0;
   int unsigned stall_count = 0;
   int unsigned sent_bytes = 0;
   int unsigned mismatches = 0;
   logic        req_calm = 1'b0;
   logic        rsp_calm = 1'b0;

   function automatic void clear_message();
      held_pair  = '0;
      group_fill = '0;
      char_count = '0;
      cap_hit    = 1'b0;
   endfunction

   // Queues the characters one input byte releases; returns 0 for a byte swallowed after the cap.
   function automatic bit encode_byte(input byte_type data, input logic last);
      logic [23:0]            group;
      logic [LIMIT_WIDTH-1:0] cap;
      enc_char_type           c;
      if (cap_hit) begin
         if (last) clear_message();
         return 1'b0;
      end
      if (group_fill < 2) begin
         if (group_fill == 0) held_pair = {data, 8'h00};
         else held_pair[7:0] = data;
         group_fill++;
         if (!last) return 1'b1;
         // The low byte is still zero when only one byte is held, which gives the padding.
         group = {held_pair, 8'h00};
      end else begin
         group = {held_pair, data};
      end
      cap = (limit_reg == 0) ? LIMIT_WIDTH'(1) : limit_reg;
      held_pair  = '0;
      group_fill = '0;
      for (int k = 0; k < GROUP_CHARS; k++) begin
         if (char_count != '1) char_count++;
         c.code    = {1'b0, group[23 - 6 * k -: 6]} + CHAR_OFFSET;
         c.closing = (char_count >= cap) || (last && k == GROUP_CHARS - 1);
         c.count   = char_count;
         pending_chars.push_back(c);
         if (char_count >= cap) begin
            cap_hit = 1'b1;
            break;
         end
      end
      if (last) clear_message();
      return 1'b1;
   endfunction

   // Input side: one beat per queued byte, after its drawn gap and, for a pause byte, once no character is pending.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            void'(encode_byte(req_tdata, req_tlast));
            sent_bytes++;
         end
         if (!req_tvalid || req_tready) begin
            if (byte_queue.size() == 0 || gap_count < byte_queue[0].gap
                || (byte_queue[0].pause && pending_chars.size() != 0)) begin
               req_tvalid <= 1'b0;
               if (byte_queue.size() != 0 && gap_count < byte_queue[0].gap) gap_count++;
            end else begin
               beat = byte_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= beat.data;
               req_tlast  <= beat.last;
               gap_count = 0;
            end
         end
      end
   end

   // Result side: compare each beat with the oldest queued character, then draw a stall.
   always @(posedge clock) begin
      enc_char_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               $error("out_char: expected no beat, got %0d", rsp_tdata[6:0]);
               mismatches++;
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata[6:0] !== want.code) begin
                  $error("out_char: expected %0d, got %0d", want.code, rsp_tdata[6:0]);
                  mismatches++;
               end
               if (rsp_tlast !== want.closing) begin
                  $error("end_of_output: expected %0d, got %0d", want.closing, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tdata[22:7] !== want.count) begin
                  $error("chars_so_far: expected %0d, got %0d", want.count, rsp_tdata[22:7]);
                  mismatches++;
               end
               if (rsp_tdata[23] !== 1'b0) begin
                  $error("tdata pad: expected 0, got %0d", rsp_tdata[23]);
                  mismatches++;
               end
            end
            stall_count = rsp_calm ? 0 : $urandom_range(0, 6);
         end else if (stall_count > 0) begin
            stall_count--;
         end
         rsp_tready <= (stall_count == 0);
      end
   end

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_limit();
      logic [31:0] rd;
      csr_access(1'b0, CSR_ADDR_LIMIT, '0, rd);
      if (rd !== {16'h0000, limit_reg}) begin
         $error("output_limit readback: expected %0d, got %0d", limit_reg, rd);
         mismatches++;
      end
   endtask

   task automatic set_limit(input logic [31:0] value);
      logic [31:0] rd;
      csr_access(1'b1, CSR_ADDR_LIMIT, value, rd);
      limit_reg = value[LIMIT_WIDTH-1:0];
      check_limit();
   endtask

   task automatic add_byte(input byte_type data, input logic last, input logic pause);
      byte_item_type it;
      it.data  = data;
      it.last  = last;
      it.gap   = req_calm ? 0 : $urandom_range(0, 6);
      it.pause = pause;
      byte_queue.push_back(it);
   endtask

   // Returns once every byte is taken and every character has come out.
   task automatic wait_drained();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_tvalid || pending_chars.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [31:0] rd;
      int unsigned n_msgs;
      int unsigned len;
      logic        open_tail;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      check_limit();

      // Full groups, a one-byte and a two-byte closing group, all-zero and all-one bytes.
      add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h00, 1'b1, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b1); add_byte(8'hFF, 1'b0, 1'b0); add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(8'h80, 1'b1, 1'b0);
      add_byte(8'h55, 1'b0, 1'b0); add_byte(8'hAA, 1'b1, 1'b0);
      add_byte(8'hC3, 1'b1, 1'b0);
      add_byte(8'h12, 1'b0, 1'b0); add_byte(8'h34, 1'b0, 1'b0); add_byte(8'h56, 1'b0, 1'b0);
      add_byte(8'h78, 1'b0, 1'b0); add_byte(8'h9A, 1'b1, 1'b0);
      wait_drained();

      // A zero limit still lets one character out; the rest of the message is swallowed.
      set_limit(32'h0000_0000);
      add_byte(8'h41, 1'b0, 1'b0); add_byte(8'h42, 1'b0, 1'b0); add_byte(8'h43, 1'b0, 1'b0);
      add_byte(8'h44, 1'b1, 1'b0);
      wait_drained();

      csr_access(1'b1, CSR_ADDR_UNUSED, 32'h0000_0002, rd);
      check_limit();
      add_byte(8'hFE, 1'b0, 1'b0); add_byte(8'h01, 1'b0, 1'b0); add_byte(8'h7F, 1'b1, 1'b0);
      wait_drained();

      // Upper write bits fall outside the 16-bit register.
      set_limit(32'hFFFF_0001);
      add_byte(8'h10, 1'b0, 1'b0); add_byte(8'h20, 1'b0, 1'b0); add_byte(8'h30, 1'b1, 1'b0);
      wait_drained();

      while (sent_bytes < SENT_TARGET) begin
         case ($urandom_range(0, 9))
            0:       set_limit(32'd1);
            1, 2:    set_limit($urandom_range(2, 12));
            3, 4:    set_limit(32'd65535);
            5:       set_limit($urandom_range(13, 65535));
            6:       set_limit(32'd0);
            default: set_limit($urandom_range(2, 40));
         endcase
         if ($urandom_range(0, 3) == 0) csr_access(1'b1, CSR_ADDR_UNUSED, $urandom, rd);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm <= ($urandom_range(0, 3) == 0);
         n_msgs = $urandom_range(2, 6);
         // Sometimes the phase stops mid-message so the next limit applies to it.
         open_tail = ($urandom_range(0, 3) == 0);
         for (int m = 0; m < n_msgs; m++) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
               add_byte(8'($urandom_range(0, 255)),
                        (i == len - 1) && !(open_tail && m == n_msgs - 1),
                        (i == 0) && ($urandom_range(0, 7) == 0));
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_chars.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
